// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fixed point alu package
// operation codes, request tag and default sizes shared by the alu modules
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int FIFO_DEPTH     = 2;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_TO_INT   = 4'd14,
    FN_FROM_INT = 4'd15
  } func_t;

  typedef struct packed {
    func_t func;
    logic  dz;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

endpackage

// File: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fixed point alu front end
// takes requests, flags a zero divisor and hands them to the queue
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [3:0]            in_func,
  input  logic [DATA_WIDTH-1:0] in_operand_a,
  input  logic [DATA_WIDTH-1:0] in_operand_b,
  input  logic                  q_full,
  output logic                  q_push,
  output fpa_pkg::tag_t         q_tag,
  output logic [DATA_WIDTH-1:0] q_a,
  output logic [DATA_WIDTH-1:0] q_b
);
  import fpa_pkg::*;

  logic                  valid_r, valid_nxt;
  tag_t                  tag_r;
  logic [DATA_WIDTH-1:0] a_r, b_r;
  logic                  take;

  assign busy   = valid_r && q_full;
  assign take   = start && !busy;
  assign q_push = valid_r && !q_full;
  assign q_tag  = tag_r;
  assign q_a    = a_r;
  assign q_b    = b_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!busy) begin
      valid_nxt = start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag_r.func <= func_t'(in_func);
      tag_r.dz   <= (func_t'(in_func) == FN_DIV) && (in_operand_b == '0);
      a_r        <= in_operand_a;
      b_r        <= in_operand_b;
    end
  end

endmodule

// File: rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fixed point alu request queue
// short fifo between front end and execution pipeline
// ----------------------------------------------------------------------------
module fpa_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import fpa_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_pop;

  assign full      = (cnt_r == CW'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fixed point alu execution pipeline
// operand stage, one restoring divide step per stage, rounding and saturation
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  fpa_pkg::tag_t         in_tag,
  input  logic [DATA_WIDTH-1:0] in_a,
  input  logic [DATA_WIDTH-1:0] in_b,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_result,
  output logic                  out_condition,
  output logic                  out_overflow,
  output logic                  out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = DW + F;
  localparam int PW = 2 * DW;
  localparam int MW = PW + 1 - F;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  // operand stage
  logic signed [DW-1:0] a, b;
  logic [DW:0]          sum, dif, inc, dec;
  logic [DW-1:0]        ma, mb;
  logic [DW-1:0]        res0;
  logic                 cond0, ovf0;
  logic                 lt, gt, fits;

  assign a = $signed(in_a);
  assign b = $signed(in_b);

  always_comb begin
    sum   = {a[DW-1], a} + {b[DW-1], b};
    dif   = {a[DW-1], a} - {b[DW-1], b};
    inc   = {a[DW-1], a} + (DW+1)'(1);
    dec   = {a[DW-1], a} - (DW+1)'(1);
    lt    = a < b;
    gt    = b < a;
    fits  = (a[DW-1 -: F+1] == {(F+1){a[DW-1]}});
    ma    = a[DW-1] ? DW'(-a) : DW'(a);
    mb    = b[DW-1] ? DW'(-b) : DW'(b);
    res0  = '0;
    cond0 = 1'b0;
    ovf0  = 1'b0;
    unique case (in_tag.func)
      FN_ADD: begin
        ovf0 = sum[DW] != sum[DW-1];
        res0 = ovf0 ? (sum[DW] ? MINV : MAXV) : sum[DW-1:0];
      end
      FN_SUB: begin
        ovf0 = dif[DW] != dif[DW-1];
        res0 = ovf0 ? (dif[DW] ? MINV : MAXV) : dif[DW-1:0];
      end
      FN_INC: begin
        ovf0 = inc[DW] != inc[DW-1];
        res0 = ovf0 ? MAXV : inc[DW-1:0];
      end
      FN_DEC: begin
        ovf0 = dec[DW] != dec[DW-1];
        res0 = ovf0 ? MINV : dec[DW-1:0];
      end
      FN_MUL: res0 = '0;
      FN_DIV: res0 = a[DW-1] ? MINV : MAXV;
      FN_GT: cond0 = gt;
      FN_LT: cond0 = lt;
      FN_GE: cond0 = !lt;
      FN_LE: cond0 = !gt;
      FN_EQ: cond0 = a == b;
      FN_NE: cond0 = a != b;
      FN_MIN: res0 = gt ? b : a;
      FN_MAX: res0 = lt ? b : a;
      FN_TO_INT: res0 = a >>> F;
      FN_FROM_INT: begin
        ovf0 = !fits;
        res0 = fits ? (a <<< F) : (a[DW-1] ? MINV : MAXV);
      end
      default: res0 = '0;
    endcase
  end

  // stage arrays, index 0 is the operand stage
  logic          v_r    [0:NW];
  tag_t          tag_r  [0:NW];
  logic [DW-1:0] res_r  [0:NW];
  logic          cond_r [0:NW];
  logic          ovf_r  [0:NW];
  logic          neg_r  [0:NW];
  logic [DW-1:0] d_r    [0:NW];
  logic [DW-1:0] rem_r  [0:NW];
  logic [NW-1:0] num_r  [0:NW];
  logic [NW-1:0] q_r    [0:NW];
  logic [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0]  <= in_tag;
    res_r[0]  <= res0;
    cond_r[0] <= cond0;
    ovf_r[0]  <= ovf0;
    neg_r[0]  <= a[DW-1] ^ b[DW-1];
    d_r[0]    <= mb;
    rem_r[0]  <= '0;
    num_r[0]  <= {ma, {F{1'b0}}};
    q_r[0]    <= '0;
    prod_r    <= PW'(ma) * PW'(mb);
  end

  // multiply rounding and saturation
  logic [PW:0]   pr;
  logic [MW-1:0] pm, mlim;
  logic          movf;
  logic [DW-1:0] mres;

  always_comb begin
    pr   = {1'b0, prod_r} + ((PW+1)'(1) << (F - 1));
    pm   = pr[PW:F];
    mlim = MW'({1'b0, MAXV}) + MW'(neg_r[0]);
    movf = pm > mlim;
    mres = movf ? (neg_r[0] ? MINV : MAXV)
                : (neg_r[0] ? DW'(-pm[DW-1:0]) : pm[DW-1:0]);
  end

  for (genvar j = 1; j <= NW; j++) begin : g_stage
    logic [DW:0]   rsh;
    logic          qb;
    logic [DW-1:0] res_in;
    logic          ovf_in;

    always_comb begin
      rsh    = {rem_r[j-1], num_r[j-1][NW-1]};
      qb     = rsh >= {1'b0, d_r[j-1]};
      res_in = res_r[j-1];
      ovf_in = ovf_r[j-1];
      if (j == 1 && tag_r[j-1].func == FN_MUL) begin
        res_in = mres;
        ovf_in = movf;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[j]  <= tag_r[j-1];
      res_r[j]  <= res_in;
      cond_r[j] <= cond_r[j-1];
      ovf_r[j]  <= ovf_in;
      neg_r[j]  <= neg_r[j-1];
      d_r[j]    <= d_r[j-1];
      rem_r[j]  <= qb ? DW'(rsh - {1'b0, d_r[j-1]}) : rsh[DW-1:0];
      num_r[j]  <= num_r[j-1] << 1;
      q_r[j]    <= {q_r[j-1][NW-2:0], qb};
    end
  end

  // divide rounding and final select
  logic [NW:0]   qr, qlim;
  logic          rnd, dovf, is_div;
  logic [DW-1:0] dres, fres;
  logic          fovf;

  always_comb begin
    rnd    = {rem_r[NW], 1'b0} >= {1'b0, d_r[NW]};
    qr     = {1'b0, q_r[NW]} + (NW+1)'(rnd);
    qlim   = (NW+1)'({1'b0, MAXV}) + (NW+1)'(neg_r[NW]);
    dovf   = qr > qlim;
    dres   = dovf ? (neg_r[NW] ? MINV : MAXV)
                  : (neg_r[NW] ? DW'(-qr[DW-1:0]) : qr[DW-1:0]);
    is_div = (tag_r[NW].func == FN_DIV) && !tag_r[NW].dz;
    fres   = is_div ? dres : res_r[NW];
    fovf   = is_div ? dovf : ovf_r[NW];
  end

  logic          ov_r;
  logic [DW-1:0] ores_r;
  logic          ocond_r, oovf_r, odz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    ores_r  <= fres;
    ocond_r <= cond_r[NW];
    oovf_r  <= fovf;
    odz_r   <= tag_r[NW].dz;
  end

  assign out_valid          = ov_r;
  assign out_result         = ores_r;
  assign out_condition      = ocond_r;
  assign out_overflow       = oovf_r;
  assign out_divide_by_zero = odz_r;

endmodule

// File: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed point alu
// saturating signed fixed-point alu with exact rounded multiply and divide
//
//   port group     direction  handshake
//   in_*, start    input      start with busy low takes a request
//   out_*          output     out_valid strobe, one cycle per result
//
// one request per cycle; results follow in request order through the front
// register, the queue and the operand, divide and output stages, the depth
// set by the divide pipeline with one quotient bit per stage. every operation
// runs through the same pipeline. reset is synchronous and clears all valid
// bits. the receiver cannot stall, so busy stays low in operation.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [3:0]            in_func,
  input  logic [DATA_WIDTH-1:0] in_operand_a,
  input  logic [DATA_WIDTH-1:0] in_operand_b,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_result,
  output logic                  out_condition,
  output logic                  out_overflow,
  output logic                  out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int QW = TAG_W + 2 * DATA_WIDTH;

  logic                  q_full, q_push, q_ne;
  tag_t                  f_tag, b_tag;
  logic [DATA_WIDTH-1:0] f_a, f_b, b_a, b_b;
  logic [QW-1:0]         q_out;

  fpa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tag        (f_tag),
    .q_a          (f_a),
    .q_b          (f_b)
  );

  fpa_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_tag, f_a, f_b}),
    .full      (q_full),
    .pop       (q_ne),
    .not_empty (q_ne),
    .pop_data  (q_out)
  );

  assign {b_tag, b_a, b_b} = q_out;

  fpa_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (q_ne),
    .in_tag             (b_tag),
    .in_a               (b_a),
    .in_b               (b_b),
    .out_valid          (out_valid),
    .out_result         (out_result),
    .out_condition      (out_condition),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

// File: rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fixed point alu checker
// port level properties of the alu, bound to the top level
// ----------------------------------------------------------------------------
module fpa_checker #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_result,
  input logic                  out_condition,
  input logic                  out_overflow,
  input logic                  out_divide_by_zero
);
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  a_start_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy) else $error("request held off");

  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow && !out_condition)
    else $error("zero divide with other flags");

  a_cond_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_condition |-> out_result == '0)
    else $error("comparison with nonzero result");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_overflow || out_divide_by_zero) |->
      (out_result == MAXV) || (out_result == MINV))
    else $error("saturated result not at a bound");

endmodule

bind fixed_point_alu fpa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_fpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_result         (out_result),
  .out_condition      (out_condition),
  .out_overflow       (out_overflow),
  .out_divide_by_zero (out_divide_by_zero)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed point alu testbench
// drives directed and random requests, takes a listed want or predicts each
// result with exact wide arithmetic and compares every strobed result in order
// ----------------------------------------------------------------------------
module tb;
  import fpa_pkg::*;

  localparam int DW = 32;
  localparam int FB = 8;
  localparam int LATENCY = DW + FB + 4;
  localparam int WATCH_LIMIT = 5000;
  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [DW-1:0] result;
    logic          condition;
    logic          overflow;
    logic          divide_by_zero;
  } alu_out_t;

  typedef struct {
    func_t         func;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          typed;
    alu_out_t      want;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_func = '0;
  logic [DW-1:0] in_operand_a = '0;
  logic [DW-1:0] in_operand_b = '0;
  logic out_valid;
  logic [DW-1:0] out_result;
  logic out_condition;
  logic out_overflow;
  logic out_divide_by_zero;

  alu_out_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  vec_t vecs[$];

  fixed_point_alu u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result(out_result), .out_condition(out_condition),
    .out_overflow(out_overflow), .out_divide_by_zero(out_divide_by_zero)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic alu_out_t sat_out(logic signed [127:0] v);
    alu_out_t o;
    o = '0;
    if (v > S_MAX) begin
      o.result = S_MAX;
      o.overflow = 1'b1;
    end else if (v < S_MIN) begin
      o.result = S_MIN;
      o.overflow = 1'b1;
    end else begin
      o.result = v[DW-1:0];
    end
    return o;
  endfunction

  function automatic alu_out_t alu_predict(func_t f, logic [DW-1:0] ra, logic [DW-1:0] rb);
    logic signed [127:0] a, b, p, q, r, mag_n, mag_d;
    logic neg;
    alu_out_t o;
    a = $signed(ra);
    b = $signed(rb);
    o = '0;
    case (f)
      FN_ADD: o = sat_out(a + b);
      FN_SUB: o = sat_out(a - b);
      FN_INC: o = sat_out(a + 1);
      FN_DEC: o = sat_out(a - 1);
      FN_MUL: begin
        neg = (a < 0) != (b < 0);
        p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        p = (p + (128'sd1 <<< (FB - 1))) >>> FB;
        o = sat_out(neg ? -p : p);
      end
      FN_DIV: begin
        if (b == 0) begin
          o.result = (a < 0) ? S_MIN : S_MAX;
          o.divide_by_zero = 1'b1;
        end else begin
          neg = (a < 0) != (b < 0);
          mag_n = (a < 0 ? -a : a) <<< FB;
          mag_d = b < 0 ? -b : b;
          q = mag_n / mag_d;
          r = mag_n % mag_d;
          if (2 * r >= mag_d) q = q + 1;
          o = sat_out(neg ? -q : q);
        end
      end
      FN_GT: o.condition = a > b;
      FN_LT: o.condition = a < b;
      FN_GE: o.condition = a >= b;
      FN_LE: o.condition = a <= b;
      FN_EQ: o.condition = a == b;
      FN_NE: o.condition = a != b;
      FN_MIN: o.result = (a <= b) ? ra : rb;
      FN_MAX: o.result = (a >= b) ? ra : rb;
      FN_TO_INT: o.result = ra >>> FB | ({DW{ra[DW-1]}} << (DW - FB));
      default: o = sat_out(a <<< FB);
    endcase
    return o;
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = S_MAX;
      1: v = S_MIN;
      2: v = '0;
      3: v = $urandom_range(0, 1) ? 32'd1 << FB : -(32'sd1 << FB);
      4, 5: v = $signed($urandom_range(0, 4095)) - 2048;
      6: v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic add_vec(func_t f, logic [DW-1:0] a, logic [DW-1:0] b, logic typed,
                         alu_out_t w);
    vec_t v;
    v.func = f;
    v.a = a;
    v.b = b;
    v.typed = typed;
    v.want = w;
    vecs.push_back(v);
  endtask

  task automatic send_request(vec_t v);
    alu_out_t w;
    w = v.typed ? v.want : alu_predict(v.func, v.a, v.b);
    start <= 1'b1;
    in_func <= v.func;
    in_operand_a <= v.a;
    in_operand_b <= v.b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(w);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) != 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    alu_out_t w;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_result);
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (out_result !== w.result) begin
          $display("%0t: result exp %h got %h", $time, w.result, out_result);
          errors++;
        end
        if (out_condition !== w.condition) begin
          $display("%0t: condition exp %b got %b", $time, w.condition, out_condition);
          errors++;
        end
        if (out_overflow !== w.overflow) begin
          $display("%0t: overflow exp %b got %b", $time, w.overflow, out_overflow);
          errors++;
        end
        if (out_divide_by_zero !== w.divide_by_zero) begin
          $display("%0t: divide_by_zero exp %b got %b", $time, w.divide_by_zero,
                   out_divide_by_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("fixed_point_alu verification failed");
      $finish;
    end
  end

  initial begin
    alu_out_t w;
    vec_t v;
    int k;
    // directed table
    w = '0; w.result = S_MAX; w.overflow = 1'b1;
    add_vec(FN_ADD, S_MAX, 32'd1, 1'b1, w);
    add_vec(FN_INC, S_MAX, 32'd0, 1'b1, w);
    add_vec(FN_MUL, S_MAX, S_MAX, 1'b1, w);
    add_vec(FN_FROM_INT, S_MAX, 32'd0, 1'b1, w);
    add_vec(FN_SUB, 32'd0, S_MIN, 1'b1, w);
    w = '0; w.result = S_MIN; w.overflow = 1'b1;
    add_vec(FN_DEC, S_MIN, 32'd0, 1'b1, w);
    add_vec(FN_SUB, S_MIN, 32'd1, 1'b1, w);
    add_vec(FN_FROM_INT, S_MIN, 32'd0, 1'b1, w);
    w = '0; w.result = S_MAX; w.divide_by_zero = 1'b1;
    add_vec(FN_DIV, 32'd5, 32'd0, 1'b1, w);
    add_vec(FN_DIV, 32'd0, 32'd0, 1'b1, w);
    w = '0; w.result = S_MIN; w.divide_by_zero = 1'b1;
    add_vec(FN_DIV, S_MIN, 32'd0, 1'b1, w);
    w = '0; w.result = 32'hffff_ffff;
    add_vec(FN_TO_INT, 32'hffff_ff01, 32'd0, 1'b1, w);
    w = '0;
    add_vec(FN_DIV, S_MIN, 32'hffff_ffff, 1'b0, w);
    add_vec(FN_MUL, 32'd384, 32'd128, 1'b0, w);
    add_vec(FN_MUL, -32'sd384, 32'd128, 1'b0, w);
    add_vec(FN_DIV, 32'd1, 32'd512, 1'b0, w);
    add_vec(FN_DIV, -32'sd1, 32'd512, 1'b0, w);
    add_vec(FN_FROM_INT, 32'h007f_ffff, 32'd0, 1'b0, w);
    add_vec(FN_FROM_INT, 32'hff80_0000, 32'd0, 1'b0, w);
    for (k = FN_GT; k <= FN_MAX; k++) begin
      add_vec(func_t'(k), 32'd7, 32'd7, 1'b0, w);
      add_vec(func_t'(k), S_MIN, S_MAX, 1'b0, w);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vecs[i]) begin
      send_request(vecs[i]);
      idle_gap();
    end
    for (k = 0; k < 450; k++) begin
      v.func = func_t'($urandom_range(0, 15));
      v.a = rand_operand();
      v.b = ($urandom_range(0, 15) == 0) ? v.a : rand_operand();
      v.typed = 1'b0;
      send_request(v);
      idle_gap();
      if (k == 200) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) $display("fixed_point_alu verification clean");
    else $display("fixed_point_alu verification failed");
    $finish;
  end

endmodule
